@@ hdl/khd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khd_pkg
// Shared types and constants of the minimum-hold key debouncer: value codes,
// sequencer states and the token that walks the ring of pending-slot cells.
// ----------------------------------------------------------------------------
package khd_pkg;

    // default sizes
    localparam int KEY_COUNT_DEF     = 256;
    localparam int PENDING_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF     = 32;

    // fixed field widths
    localparam int KEY_BITS = 8;
    localparam int VAL_BITS = 2;
    // wide enough to compare a key code against any key count up to 1024
    localparam int KEY_CMP_W = 11;

    // hold time register
    localparam logic [7:0] HOLD_MAX   = 8'd250;
    localparam logic [7:0] HOLD_RESET = 8'd50;

    // most releases one tick may pass on
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // request kinds
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // key values
    localparam logic [VAL_BITS-1:0] VAL_UP     = 2'd0;
    localparam logic [VAL_BITS-1:0] VAL_DOWN   = 2'd1;
    localparam logic [VAL_BITS-1:0] VAL_REPEAT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INJECT,
        ST_SCAN,
        ST_EMIT,
        ST_FLUSH
    } khd_state_t;

    // what a token asks of each slot cell it passes
    typedef enum logic [1:0] {
        TOK_TICK,
        TOK_CANCEL,
        TOK_PROBE,
        TOK_FILL
    } tok_mode_t;

    typedef struct packed {
        logic                active;
        tok_mode_t           mode;
        logic [KEY_BITS-1:0] key;
        logic                done;
        logic [CNT_W-1:0]    hits;
        logic                pend_found;
        logic                free_found;
        logic                rel_valid;
        logic [KEY_BITS-1:0] rel_key;
    } slot_token_t;

endpackage

@@ hdl/key_minimum_hold_debounce_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_minimum_hold_debounce_top
// Eager per-key debouncer with a minimum hold time, built around a ring of
// pending-release slot cells walked by a token.
// ----------------------------------------------------------------------------
// Requests are key events (up, down, repeat) or one-millisecond ticks, taken
// one at a time. A down on a released key passes at once and stamps the press
// time; an up that comes sooner than hold_time_ms after the press is parked in
// one of PENDING_SLOTS slots and passed on by the tick that reaches its
// deadline, while a down that meets a parked release cancels it. With all
// slots busy the short release passes at once with forced set. A key event
// that needs no slot search is accepted and then loaded into the output
// register, and an ignored one ends with its accept. A down on a pressed
// key, an up on a pressed key and every tick send a token through the chain
// of slot cells, one cell per cycle while the ring is not frozen: accept,
// inject and a scan through all PENDING_SLOTS cells, followed by the final
// result load when an up passes at once or a tick releases keys. An up that
// parks a release walks the chain twice. A tick may release up to eight
// keys; each release after the first waits for the output register, so a
// stalled consumer stretches the tick. Results leave through one output
// register, and the next request is taken while a result there still
// waits. There is no clearing pass after reset: press stamps live in a RAM
// that is only read for keys known to be pressed. hold_time_ms saturates
// at 250 and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module key_minimum_hold_debounce_top #(
    parameter int KEY_COUNT     = khd_pkg::KEY_COUNT_DEF,
    parameter int PENDING_SLOTS = khd_pkg::PENDING_SLOTS_DEF,
    parameter int TIME_BITS     = khd_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] key_code,
    input  logic [1:0] key_value,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_key,
    output logic [1:0] out_value,
    output logic       forced,
    output logic       last,
    // hold time register
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    import khd_pkg::*;

    localparam int KEY_W = $clog2(KEY_COUNT);

    // sequencer state
    khd_state_t           state_reg;
    khd_state_t           state_next;
    tok_mode_t            mode_reg;
    tok_mode_t            mode_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    logic [VAL_BITS-1:0]  res_value_reg;
    logic [VAL_BITS-1:0]  res_value_next;
    logic                 res_forced_reg;
    logic                 res_forced_next;

    // block state
    logic [TIME_BITS-1:0] time_now_reg;
    logic [TIME_BITS-1:0] time_now_next;
    logic [7:0]           hold_reg;
    logic [7:0]           hold_next;
    logic [KEY_COUNT-1:0] key_down_reg;
    logic [KEY_COUNT-1:0] key_down_next;

    // last release of a tick, held back until we know whether it is the final one
    logic                 held_valid_reg;
    logic                 held_valid_next;
    logic [KEY_BITS-1:0]  held_key_reg;
    logic [KEY_BITS-1:0]  held_key_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KEY_BITS-1:0]  out_key_reg;
    logic [KEY_BITS-1:0]  out_key_next;
    logic [VAL_BITS-1:0]  out_value_reg;
    logic [VAL_BITS-1:0]  out_value_next;
    logic                 out_forced_reg;
    logic                 out_forced_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 out_can_load;

    // handshake and decode
    logic                 accept;
    logic                 key_in_range;
    logic [KEY_W-1:0]     in_idx;
    logic [KEY_W-1:0]     cur_idx;

    // press stamp memory
    logic                 ram_we;
    logic                 ram_re;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] fill_deadline;
    logic                 short_hold;

    // slot ring
    slot_token_t          tok_link [PENDING_SLOTS+1];
    slot_token_t          tok_last;
    logic                 advance;
    logic                 rel_any;
    logic [KEY_BITS-1:0]  rel_key;

    assign accept       = in_valid && !in_stall;
    assign in_stall     = (state_reg != ST_IDLE);
    assign key_in_range = {{(KEY_CMP_W-KEY_BITS){1'b0}}, key_code} < KEY_CMP_W'(KEY_COUNT);
    assign in_idx       = KEY_W'(key_code);
    assign cur_idx      = KEY_W'(key_reg);
    assign out_can_load = !out_valid_reg || !out_stall;

    // release timing for the key in flight
    assign elapsed       = time_now_reg - stamp;
    assign short_hold    = elapsed < TIME_BITS'(hold_reg);
    assign fill_deadline = stamp + TIME_BITS'(hold_reg);

    // press stamps, written on a fresh down and read for an up on a pressed key
    khd_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (KEY_COUNT)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (time_now_reg),
        .re    (ram_re),
        .raddr (in_idx),
        .rdata (stamp)
    );

    // chain of slot cells; the token moves one cell per cycle while the ring advances
    genvar g;
    generate
        for (g = 0; g < PENDING_SLOTS; g++)
        begin : g_cell
            khd_slot_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .advance       (advance),
                .time_now      (time_now_reg),
                .fill_deadline (fill_deadline),
                .tok_up        (tok_link[g]),
                .tok_dn        (tok_link[g+1])
            );
        end
    endgenerate

    assign tok_last = tok_link[PENDING_SLOTS];

    // only one token is ever in the ring, so at most one cell releases
    always_comb
    begin
        rel_any = 1'b0;
        rel_key = '0;
        for (int i = 1; i <= PENDING_SLOTS; i++)
        begin
            if (tok_link[i].active && tok_link[i].rel_valid)
            begin
                rel_any = 1'b1;
                rel_key = rel_key | tok_link[i].rel_key;
            end
        end
    end

    // freeze the ring while a release has nowhere to go
    assign advance = !(rel_any && held_valid_reg && !out_can_load);

    // hold time register, saturating
    always_comb
    begin
        hold_next = hold_reg;
        if (cfg_wr_en)
        begin
            hold_next = (cfg_wr_data > HOLD_MAX) ? HOLD_MAX : cfg_wr_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_forced_next = res_forced_reg;
        time_now_next   = time_now_reg;
        key_down_next   = key_down_reg;
        held_valid_next = held_valid_reg;
        held_key_next   = held_key_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        tok_link[0]     = '0;

        out_valid_next  = out_valid_reg && out_stall;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_forced_next = out_forced_reg;
        out_last_next   = out_last_reg;

        // a tick release: the previously held one goes out, this one is held
        if (advance && rel_any)
        begin
            key_down_next[KEY_W'(rel_key)] = 1'b0;
            held_valid_next = 1'b1;
            held_key_next   = rel_key;
            if (held_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_key_next    = held_key_reg;
                out_value_next  = VAL_UP;
                out_forced_next = 1'b0;
                out_last_next   = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next        = key_code;
                    res_forced_next = 1'b0;
                    if (op == OP_TICK)
                    begin
                        time_now_next = time_now_reg + TIME_BITS'(1);
                        mode_next     = TOK_TICK;
                        state_next    = ST_INJECT;
                    end
                    else if (key_in_range)
                    begin
                        case (key_value)
                            VAL_DOWN:
                            begin
                                if (!key_down_reg[in_idx])
                                begin
                                    key_down_next[in_idx] = 1'b1;
                                    ram_we         = 1'b1;
                                    res_value_next = VAL_DOWN;
                                    state_next     = ST_EMIT;
                                end
                                else
                                begin
                                    // a pending release of this key is cancelled
                                    mode_next  = TOK_CANCEL;
                                    state_next = ST_INJECT;
                                end
                            end
                            VAL_UP:
                            begin
                                if (!key_down_reg[in_idx])
                                begin
                                    res_value_next = VAL_UP;
                                    state_next     = ST_EMIT;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    mode_next  = TOK_PROBE;
                                    state_next = ST_INJECT;
                                end
                            end
                            VAL_REPEAT:
                            begin
                                res_value_next = VAL_REPEAT;
                                state_next     = ST_EMIT;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_INJECT:
            begin
                tok_link[0].active = 1'b1;
                tok_link[0].mode   = mode_reg;
                tok_link[0].key    = key_reg;
                state_next         = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (advance && tok_last.active)
                begin
                    case (mode_reg)
                        TOK_TICK:
                        begin
                            state_next = held_valid_next ? ST_FLUSH : ST_IDLE;
                        end
                        TOK_PROBE:
                        begin
                            if (tok_last.pend_found)
                            begin
                                // release already parked
                                state_next = ST_IDLE;
                            end
                            else if (short_hold && tok_last.free_found)
                            begin
                                mode_next  = TOK_FILL;
                                state_next = ST_INJECT;
                            end
                            else
                            begin
                                // long enough held, or no slot left
                                key_down_next[cur_idx] = 1'b0;
                                res_value_next  = VAL_UP;
                                res_forced_next = short_hold;
                                state_next      = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (out_can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = key_reg;
                    out_value_next  = res_value_reg;
                    out_forced_next = res_forced_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (out_can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = held_key_reg;
                    out_value_next  = VAL_UP;
                    out_forced_next = 1'b0;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= TOK_TICK;
            time_now_reg   <= '0;
            hold_reg       <= HOLD_RESET;
            key_down_reg   <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            time_now_reg   <= time_now_next;
            hold_reg       <= hold_next;
            key_down_reg   <= key_down_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_forced_reg <= res_forced_next;
        held_key_reg   <= held_key_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_forced_reg <= out_forced_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_value_reg;
    assign forced    = out_forced_reg;
    assign last      = out_last_reg;

endmodule

@@ hdl/khd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module khd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/khd_slot_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khd_slot_cell
// One pending-release slot. Holds key and deadline, acts on the token that
// passes through it and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module khd_slot_cell #(
    parameter int TIME_BITS = khd_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] time_now,
    input  logic [TIME_BITS-1:0] fill_deadline,
    input  khd_pkg::slot_token_t tok_up,
    output khd_pkg::slot_token_t tok_dn
);

    import khd_pkg::*;

    slot_token_t          tok_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_BITS-1:0]  slot_key_reg;
    logic [KEY_BITS-1:0]  slot_key_next;
    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] deadline_next;
    logic [TIME_BITS-1:0] lag;
    logic                 due;
    logic                 hit;

    always_comb
    begin
        // deadline reached when the wrapped lag lies in the lower half
        lag           = time_now - deadline_reg;
        due           = valid_reg && !lag[TIME_BITS-1];
        hit           = valid_reg && (slot_key_reg == tok_reg.key);
        tok_dn           = tok_reg;
        tok_dn.rel_valid = 1'b0;
        tok_dn.rel_key   = slot_key_reg;
        valid_next    = valid_reg;
        slot_key_next = slot_key_reg;
        deadline_next = deadline_reg;
        if (tok_reg.active)
        begin
            case (tok_reg.mode)
                TOK_TICK:
                begin
                    if (due && (tok_reg.hits < CNT_W'(MAX_OUT)))
                    begin
                        valid_next       = 1'b0;
                        tok_dn.hits      = tok_reg.hits + CNT_W'(1);
                        tok_dn.rel_valid = 1'b1;
                    end
                end
                TOK_CANCEL:
                begin
                    if (!tok_reg.done && hit)
                    begin
                        valid_next  = 1'b0;
                        tok_dn.done = 1'b1;
                    end
                end
                TOK_PROBE:
                begin
                    if (hit)
                    begin
                        tok_dn.pend_found = 1'b1;
                    end
                    if (!valid_reg)
                    begin
                        tok_dn.free_found = 1'b1;
                    end
                end
                TOK_FILL:
                begin
                    if (!tok_reg.done && !valid_reg)
                    begin
                        valid_next    = 1'b1;
                        slot_key_next = tok_reg.key;
                        deadline_next = fill_deadline;
                        tok_dn.done   = 1'b1;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg   <= tok_up;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_key_reg <= slot_key_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule
